// File: hw/rtl/tem_pkg.sv
// ----------------------------------------------------------------------------
// tem_pkg: shared types and constants of the text extent measure block
// Item and configuration structs, codepoint codes, register indexes and the
// state type of the execution sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tem_pkg;

  // Control codepoints
  localparam logic [20:0] CP_END = 21'd0;
  localparam logic [20:0] CP_TAB = 21'd9;
  localparam logic [20:0] CP_LF  = 21'd10;
  localparam logic [20:0] CP_CR  = 21'd13;

  // Stream widths
  localparam int IN_TDATA_BITS  = 104;
  localparam int OUT_TDATA_BITS = 32;

  // Configuration port
  localparam int CFG_INDEX_BITS = 4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_LINE_WIDTH = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_HEIGHT    = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EM_ADVANCE     = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TAB_COLUMNS    = 4'd3;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    KIND_GLYPH,
    KIND_TAB,
    KIND_CR,
    KIND_LF,
    KIND_END
  } kind_t;

  // Classified item: glyph metrics already folded into two offsets
  typedef struct packed {
    kind_t              kind;
    logic signed [17:0] right_off;  // glyph_width + offset_x
    logic signed [17:0] bottom;     // glyph_height + offset_y
    logic [15:0]        advance;
    logic               eot;
  } item_t;

  typedef struct packed {
    logic [15:0] max_line_width;
    logic [15:0] line_height;
    logic [15:0] em_advance;
    logic [15:0] tab_columns;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAB_DIV,
    S_TAB_WRAP,
    S_GROW,
    S_EMIT
  } back_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/tem_front.sv
// ----------------------------------------------------------------------------
// tem_front: input stage
// Takes stream transfers, classifies the codepoint and precomputes the glyph
// offsets, then hands the item on to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tem_front
  import tem_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // codepoint, glyph_width, glyph_height, offset_x, offset_y, advance, zero pad
  input  wire logic [IN_TDATA_BITS-1:0] s_tdata,
  input  wire logic                     s_tlast,
  output logic                          push_valid,
  input  wire logic                     push_ready,
  output item_t                         push_item
);

  logic        held;
  item_t       item;
  item_t       item_next;
  logic [20:0] cp;
  logic [15:0] glyph_width;
  logic [15:0] glyph_height;
  logic [15:0] offset_x;
  logic [15:0] offset_y;

  assign cp           = s_tdata[20:0];
  assign glyph_width  = s_tdata[36:21];
  assign glyph_height = s_tdata[52:37];
  assign offset_x     = s_tdata[68:53];
  assign offset_y     = s_tdata[84:69];

  // Classify and fold the metrics
  always_comb begin
    case (cp)
      CP_END:  item_next.kind = KIND_END;
      CP_TAB:  item_next.kind = KIND_TAB;
      CP_LF:   item_next.kind = KIND_LF;
      CP_CR:   item_next.kind = KIND_CR;
      default: item_next.kind = KIND_GLYPH;
    endcase
    item_next.right_off = $signed({2'b00, glyph_width})
                          + $signed({{2{offset_x[15]}}, offset_x});
    item_next.bottom    = $signed({2'b00, glyph_height})
                          + $signed({{2{offset_y[15]}}, offset_y});
    item_next.advance   = s_tdata[100:85];
    item_next.eot       = s_tlast;
  end

  assign s_tready   = !held || push_ready;
  assign push_valid = held;
  assign push_item  = item;

  // Holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tem_queue.sv
// ----------------------------------------------------------------------------
// tem_queue: short item queue
// Decouples the input stage from the execution sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tem_queue
  import tem_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire item_t push_item,
  output logic       pop_valid,
  input  wire logic  pop,
  output item_t      pop_item
);

  localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  item_t                 entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [COUNT_BITS-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count != COUNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  function automatic logic [PTR_BITS-1:0] bump(input logic [PTR_BITS-1:0] p);
    if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tem_rem.sv
// ----------------------------------------------------------------------------
// tem_rem: iterative remainder unit
// Restoring division, one quotient bit per cycle; gives dividend mod divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module tem_rem #(
  parameter int WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  output logic                  done,
  output logic [WIDTH-1:0]      remainder
);

  localparam int CNT_BITS = $clog2(WIDTH + 1);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [WIDTH-1:0]    rem;
  logic [WIDTH-1:0]    quo;
  logic [WIDTH-1:0]    div;
  logic [WIDTH:0]      trial;
  logic [WIDTH:0]      diff;

  // One restoring step
  assign trial     = {rem, quo[WIDTH-1]};
  assign diff      = trial - {1'b0, div};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      div <= divisor;
    end else if (busy) begin
      quo <= {quo[WIDTH-2:0], 1'b0};
      if (!diff[WIDTH]) begin
        rem <= diff[WIDTH-1:0];
      end else begin
        rem <= trial[WIDTH-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tem_back.sv
// ----------------------------------------------------------------------------
// tem_back: execution sequencer
// Keeps the pen and the extents, carries out one queued item at a time and
// drives the registered result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tem_back
  import tem_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cfg_t                      cfg,
  input  wire logic                      q_valid,
  output logic                           q_pop,
  input  wire item_t                     q_item,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // area_width, area_height
  output logic [OUT_TDATA_BITS-1:0]      m_tdata
);

  localparam int MW   = (COORD_BITS > 16) ? COORD_BITS : 16;
  localparam int GW   = (COORD_BITS > 17) ? COORD_BITS : 17;
  localparam int SUMW = GW + 1;
  localparam int TW   = (COORD_BITS + 1 > 18) ? COORD_BITS + 1 : 18;

  back_state_t state;
  back_state_t state_next;

  logic [COORD_BITS-1:0] pen_x;
  logic [COORD_BITS-1:0] pen_y;
  logic [COORD_BITS-1:0] extent_x;
  logic [COORD_BITS-1:0] extent_y;
  logic                  at_text_start;
  logic                  skipping_rest;

  logic                  item_eot;
  logic                  end_skip;
  logic [COORD_BITS-1:0] right;
  logic [GW-1:0]         grow_add;
  logic                  grow_x;
  logic [COORD_BITS-1:0] cw;
  logic [31:0]           cw_full;

  logic [COORD_BITS-1:0] lh;
  logic [COORD_BITS-1:0] pen_y_lf;
  logic [COORD_BITS-1:0] roff;
  logic [COORD_BITS-1:0] right_sum;
  logic                  glyph_wrap;
  logic signed [TW-1:0]  bottom_ext;
  logic signed [TW-1:0]  lh_ext;
  logic [GW-1:0]         tail;
  logic                  tab_wrap;
  logic [SUMW-1:0]       grow_sum;
  logic [MW-1:0]         clamped;

  logic                  div_start;
  logic                  div_done;
  logic [COORD_BITS-1:0] div_rem;
  logic                  load_out;
  logic                  clear_req;

  // Datapath helpers
  assign lh         = COORD_BITS'(cfg.line_height);
  assign pen_y_lf   = pen_y + lh;
  assign roff       = COORD_BITS'(q_item.right_off);
  assign right_sum  = pen_x + roff;
  assign glyph_wrap = MW'(right_sum) > MW'(cfg.max_line_width);
  assign bottom_ext = TW'(q_item.bottom);
  assign lh_ext     = $signed(TW'(lh));
  assign tail       = (bottom_ext > lh_ext) ? GW'(q_item.bottom[16:0]) : GW'(lh);
  assign tab_wrap   = MW'(pen_x) >= MW'(cfg.max_line_width);
  assign grow_sum   = SUMW'(pen_y) + SUMW'(grow_add);
  assign clamped    = (MW'(extent_x) > MW'(cfg.max_line_width)) ?
                      MW'(cfg.max_line_width) : MW'(extent_x);
  assign cw_full    = cfg.em_advance * cfg.tab_columns;

  tem_rem #(
    .WIDTH (COORD_BITS)
  ) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (pen_x),
    .divisor   (cw),
    .done      (div_done),
    .remainder (div_rem)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    clear_req  = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (skipping_rest) begin
            clear_req = q_item.eot;
          end else begin
            case (q_item.kind)
              KIND_END:   state_next = S_EMIT;
              KIND_CR:    state_next = q_item.eot ? S_EMIT : S_IDLE;
              KIND_LF:    state_next = S_GROW;
              KIND_GLYPH: state_next = S_GROW;
              KIND_TAB: begin
                if (cw != '0) begin
                  div_start  = 1'b1;
                  state_next = S_TAB_DIV;
                end else begin
                  state_next = S_TAB_WRAP;
                end
              end
              default:    state_next = S_IDLE;
            endcase
          end
        end
      end
      S_TAB_DIV: begin
        if (div_done) begin
          state_next = S_TAB_WRAP;
        end
      end
      S_TAB_WRAP: begin
        if (tab_wrap) begin
          state_next = S_GROW;
        end else begin
          state_next = item_eot ? S_EMIT : S_IDLE;
        end
      end
      S_GROW: begin
        state_next = item_eot ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          clear_req  = !end_skip;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Pen, extents and text flags
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x         <= '0;
      pen_y         <= '0;
      extent_x      <= '0;
      extent_y      <= '0;
      at_text_start <= 1'b1;
      skipping_rest <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid && !skipping_rest && q_item.kind != KIND_END) begin
            at_text_start <= 1'b0;
            if (at_text_start && !q_item.eot) begin
              extent_y <= lh;
            end
            case (q_item.kind)
              KIND_CR: pen_x <= '0;
              KIND_LF: begin
                pen_x <= '0;
                pen_y <= pen_y_lf;
              end
              KIND_GLYPH: begin
                if (glyph_wrap) begin
                  pen_x <= '0;
                  pen_y <= pen_y_lf;
                end else begin
                  pen_x <= pen_x + COORD_BITS'(q_item.advance);
                end
              end
              default: ;
            endcase
          end
        end
        S_TAB_DIV: begin
          if (div_done) begin
            pen_x <= pen_x - div_rem + cw;
          end
        end
        S_TAB_WRAP: begin
          if (tab_wrap) begin
            pen_x <= '0;
            pen_y <= pen_y_lf;
          end else if (pen_x > extent_x) begin
            extent_x <= pen_x;
          end
        end
        S_GROW: begin
          if (grow_sum > SUMW'(extent_y)) begin
            extent_y <= grow_sum[COORD_BITS-1:0];
          end
          if (grow_x && right > extent_x) begin
            extent_x <= right;
          end
        end
        S_EMIT: begin
          if (load_out && end_skip) begin
            skipping_rest <= 1'b1;
          end
        end
        default: ;
      endcase
      // End of text returns the measurement to its start
      if (clear_req) begin
        pen_x         <= '0;
        pen_y         <= '0;
        extent_x      <= '0;
        extent_y      <= '0;
        at_text_start <= 1'b1;
        skipping_rest <= 1'b0;
      end
    end
  end

  // Working registers of the current item
  always_ff @(posedge clk) begin
    cw <= cw_full[COORD_BITS-1:0];
    if (state == S_IDLE && q_valid) begin
      item_eot <= q_item.eot;
      end_skip <= (q_item.kind == KIND_END) && !q_item.eot;
      grow_add <= (q_item.kind == KIND_GLYPH) ? tail : GW'(lh);
      grow_x   <= (q_item.kind == KIND_GLYPH);
      right    <= glyph_wrap ? roff : right_sum;
    end else if (state == S_TAB_WRAP) begin
      grow_add <= GW'(lh);
      grow_x   <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {16'(extent_y), clamped[15:0]};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/text_extent_measure.sv
// ----------------------------------------------------------------------------
// text_extent_measure: running text extent of a codepoint stream
// Top level: configuration registers, input stage, queue and sequencer.
// ----------------------------------------------------------------------------
// The input stage holds one transfer and feeds a two-entry queue, so up to
// three items can wait while the sequencer is busy or a result is held up;
// after that the input is stalled. The sequencer handles a return or a skipped
// item in its idle state, passes a glyph or a line feed through S_GROW, and
// takes a tab through S_TAB_DIV, where the remainder unit finds one quotient
// bit per cycle, and S_TAB_WRAP, then S_GROW when the tab wraps. A tab with a
// zero tab stop skips the remainder unit and goes straight to S_TAB_WRAP. An
// item that emits a result then passes S_EMIT to load the result register, and
// the sequencer waits there while the receiver holds off. Registers are written
// through the cfg port, which is always ready.
`default_nettype none

module text_extent_measure
  import tem_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // codepoint[20:0], glyph_width[36:21], glyph_height[52:37],
  // offset_x[68:53], offset_y[84:69], advance[100:85], zero pad[103:101]
  input  wire logic [IN_TDATA_BITS-1:0]  s_tdata,
  input  wire logic                      s_tlast,   // end_of_text
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // area_width[15:0], area_height[31:16]
  output logic [OUT_TDATA_BITS-1:0]      m_tdata,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [15:0]               cfg_data
);

  cfg_t  cfg;
  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_line_width <= 16'd65535;
      cfg.line_height    <= 16'd16;
      cfg.em_advance     <= 16'd8;
      cfg.tab_columns    <= 16'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_LINE_WIDTH: cfg.max_line_width <= cfg_data;
        REG_LINE_HEIGHT:    cfg.line_height    <= cfg_data;
        REG_EM_ADVANCE:     cfg.em_advance     <= cfg_data;
        REG_TAB_COLUMNS:    cfg.tab_columns    <= cfg_data;
        default: ;
      endcase
    end
  end

  tem_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  tem_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  tem_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the text extent measure block
// Feeds texts of glyphs, tabs, returns, line feeds and end codes through the
// input stream. Each transfer is run through a local pen and extent tracker,
// and the area results that come back are compared field by field. The four
// layout registers are reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------

module tb_top;
  import tem_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int HOLD_AT      = 400;   // input transfers before the long stall
  localparam int HOLD_CYCLES  = 500;
  localparam int SETTLE       = 80;    // quiet cycles before a register write
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 4'd9;

  typedef struct {
    logic [20:0]        cp;
    logic [15:0]        gw;
    logic [15:0]        gh;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic [15:0]        adv;
    logic               eot;
  } text_char_t;

  typedef struct {
    logic [15:0] w;
    logic [15:0] h;
  } area_t;

  // DUT ports
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
  logic                      s_tlast = 1'b0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [15:0]               cfg_data = '0;

  // Local copy of the layout registers
  logic [15:0] wrap_w    = 16'hFFFF;
  logic [15:0] line_step = 16'd16;
  logic [15:0] em_w      = 16'd8;
  logic [15:0] tab_ems   = 16'd4;

  // Local pen and extent state
  logic [15:0] cur_x = '0;
  logic [15:0] cur_y = '0;
  logic [15:0] span_x = '0;
  logic [15:0] span_y = '0;
  logic        fresh_text = 1'b1;
  logic        skip_to_end = 1'b0;

  text_char_t pending_chars[$];
  area_t      area_q[$];
  text_char_t drv_item;

  int  pushed_count = 0;
  int  in_count;
  int  mismatches = 0;
  int  cycles = 0;
  int  s_gap = 0;
  int  m_gap = 0;
  int  hold_left;
  logic hold_done;
  logic s_fire = 1'b0;
  logic m_fire = 1'b0;
  logic idle_on = 1'b1;

  text_extent_measure #(.COORD_BITS(16)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Tracker of pen position and text extent
  // --------------------------------------------------------------------------
  task automatic clear_text();
    cur_x = '0;
    cur_y = '0;
    span_x = '0;
    span_y = '0;
    fresh_text = 1'b1;
    skip_to_end = 1'b0;
  endtask

  task automatic grow_span_y(input longint sum);
    if (sum > longint'(span_y)) span_y = 16'(sum);
  endtask

  task automatic push_area();
    area_t a;
    a.w = (span_x > wrap_w) ? wrap_w : span_x;
    a.h = span_y;
    area_q.push_back(a);
  endtask

  task automatic measure_char(input text_char_t c);
    logic [15:0] cw;
    logic [15:0] right_w;
    longint      bottom;
    longint      tail;
    if (skip_to_end) begin
      if (c.eot) clear_text();
    end else if (c.cp == CP_END) begin
      // end code: report as it stands, then drop items up to the marked last
      push_area();
      if (c.eot) clear_text();
      else skip_to_end = 1'b1;
    end else begin
      if (fresh_text) begin
        fresh_text = 1'b0;
        if (!c.eot) span_y = line_step;
      end
      case (c.cp)
        CP_TAB: begin
          cw = 16'(32'(em_w) * 32'(tab_ems));
          // zero tab stop leaves the pen where it is
          if (cw != 0) cur_x = 16'((32'(cur_x) / 32'(cw) + 32'd1) * 32'(cw));
          if (cur_x >= wrap_w) begin
            cur_x = '0;
            cur_y = cur_y + line_step;
            grow_span_y(longint'(cur_y) + longint'(line_step));
          end
          if (cur_x > span_x) span_x = cur_x;
        end
        CP_CR: cur_x = '0;
        CP_LF: begin
          cur_y = cur_y + line_step;
          grow_span_y(longint'(cur_y) + longint'(line_step));
          cur_x = '0;
        end
        default: begin
          bottom = longint'(c.gh) + longint'(c.oy);
          tail = (bottom > longint'(line_step)) ? bottom : longint'(line_step);
          right_w = 16'(longint'(cur_x) + longint'(c.gw) + longint'(c.ox));
          if (right_w > wrap_w) begin
            cur_x = '0;
            right_w = 16'(longint'(c.gw) + longint'(c.ox));
            cur_y = cur_y + line_step;
          end else begin
            cur_x = cur_x + c.adv;
          end
          grow_span_y(longint'(cur_y) + tail);
          if (right_w > span_x) span_x = right_w;
        end
      endcase
      if (c.eot) begin
        push_area();
        clear_text();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    return idle_on ? int'($urandom_range(0, 9)) : 0;
  endfunction

  function automatic logic [15:0] rand_metric();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'($urandom_range(0, 40));
    else if (r < 9) return 16'($urandom_range(0, 2000));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_offset();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'(int'($urandom_range(0, 16)) - 8);
    else if (r < 9) return 16'(int'($urandom_range(0, 400)) - 200);
    return 16'($urandom);
  endfunction

  function automatic text_char_t rand_char();
    text_char_t c;
    int r;
    c.gw = rand_metric();
    c.gh = rand_metric();
    c.ox = rand_offset();
    c.oy = rand_offset();
    c.adv = rand_metric();
    c.eot = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 14) c.cp = CP_TAB;
    else if (r < 21) c.cp = CP_LF;
    else if (r < 26) c.cp = CP_CR;
    else if (r < 28) c.cp = CP_END;
    else if (r < 70) c.cp = 21'($urandom_range(32, 126));
    else if (r < 92) c.cp = 21'($urandom_range(128, 1114111));
    else c.cp = 21'($urandom_range(0, 1114111));
    return c;
  endfunction

  task automatic queue_char(input text_char_t c);
    pending_chars.push_back(c);
    pushed_count++;
  endtask

  task automatic queue_fields(input logic [20:0] cp, input logic [15:0] gw, gh,
                              input logic [15:0] ox, oy, adv, input logic eot);
    text_char_t c;
    c.cp = cp;
    c.gw = gw;
    c.gh = gh;
    c.ox = ox;
    c.oy = oy;
    c.adv = adv;
    c.eot = eot;
    queue_char(c);
  endtask

  // One text: mostly well formed with random content, sometimes raw noise
  task automatic queue_text();
    text_char_t c;
    int n;
    n = $urandom_range(1, 12);
    if ($urandom_range(0, 19) == 0) begin
      for (int i = 0; i < n; i++) begin
        c.cp = 21'($urandom_range(0, 1114111));
        c.gw = 16'($urandom);
        c.gh = 16'($urandom);
        c.ox = 16'($urandom);
        c.oy = 16'($urandom);
        c.adv = 16'($urandom);
        c.eot = 1'($urandom_range(0, 1));
        queue_char(c);
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        c = rand_char();
        c.eot = (i == n - 1);
        queue_char(c);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MAX_LINE_WIDTH: wrap_w = val;
      REG_LINE_HEIGHT:    line_step = val;
      REG_EM_ADVANCE:     em_w = val;
      REG_TAB_COLUMNS:    tab_ems = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Block idle: every item taken, every area back, then a quiet stretch
  task automatic wait_idle();
    while (in_count != pushed_count || area_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic run_phase(input logic [15:0] mlw, lh, em, tc, input int n_items);
    int target;
    write_reg(REG_MAX_LINE_WIDTH, mlw);
    write_reg(REG_LINE_HEIGHT, lh);
    write_reg(REG_EM_ADVANCE, em);
    write_reg(REG_TAB_COLUMNS, tc);
    idle_on = ($urandom_range(0, 3) != 0);
    target = pushed_count + n_items;
    while (pushed_count < target) queue_text();
    wait_idle();
  endtask

  task automatic check_field(input string name, input logic [15:0] want, got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sampling at the rising edge: scoreboard and tracker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    area_t want;
    if (rst) begin
      s_fire <= 1'b0;
      m_fire <= 1'b0;
      in_count <= 0;
    end else begin
      s_fire <= s_tvalid && s_tready;
      m_fire <= m_tvalid && m_tready;
      if (m_tvalid && m_tready) begin
        if (area_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected area result %0d x %0d", $time,
                     m_tdata[15:0], m_tdata[31:16]);
        end else begin
          want = area_q.pop_front();
          check_field("area_width", want.w, m_tdata[15:0]);
          check_field("area_height", want.h, m_tdata[31:16]);
        end
      end
      if (s_tvalid && s_tready) begin
        measure_char(drv_item);
        in_count <= in_count + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input driver: one pending item per transfer, random gap after each
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    text_char_t nxt;
    if (!rst && !(s_tvalid && !s_fire)) begin
      if (s_gap != 0) begin
        s_gap <= s_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_chars.size() != 0) begin
        nxt = pending_chars.pop_front();
        drv_item <= nxt;
        s_tdata <= {3'b000, nxt.adv, nxt.oy, nxt.ox, nxt.gh, nxt.gw, nxt.cp};
        s_tlast <= nxt.eot;
        s_tvalid <= 1'b1;
        s_gap <= pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result side ready: random stall after each transfer, or the long hold
  always @(negedge clk) begin
    int g;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
    end else if (m_fire) begin
      g = pick_gap();
      m_gap <= g;
      m_tready <= (g == 0);
    end else if (m_gap != 0) begin
      m_gap <= m_gap - 1;
      m_tready <= (m_gap == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Long receiver hold so the input queue fills and backs up
  always @(negedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && in_count >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [15:0] mlw, lh, em, tc;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed texts under the reset register values
    // end code as the first item, then skipped items up to the marked last
    queue_fields(CP_END, 16'd3, 16'd3, 16'd0, 16'd0, 16'd3, 1'b0);
    queue_fields(21'd65, 16'd9, 16'd9, 16'd0, 16'd0, 16'd9, 1'b0);
    queue_fields(21'd66, 16'd9, 16'd9, 16'd0, 16'd0, 16'd9, 1'b1);
    // single glyph that is first and last at once
    queue_fields(21'd72, 16'd5, 16'd7, 16'd1, 16'hFFFE, 16'd6, 1'b1);
    // tab, return and line feed codes, extreme metrics, top codepoint
    queue_fields(CP_TAB, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0);
    queue_fields(CP_TAB, 16'd0, 16'd0, 16'h8000, 16'h8000, 16'd0, 1'b0);
    queue_fields(CP_CR, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 1'b0);
    queue_fields(CP_LF, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 1'b0);
    queue_fields(21'd120, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0);
    queue_fields(21'd121, 16'd0, 16'd0, 16'h8000, 16'h8000, 16'd0, 1'b0);
    queue_fields(21'd120, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 1'b0);
    queue_fields(21'h10FFFF, 16'd10, 16'd20, 16'd0, 16'd0, 16'd10, 1'b1);
    // end code that is also marked last, as the first item
    queue_fields(CP_END, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    // end code in the middle of a text, marked last
    queue_fields(21'd77, 16'd12, 16'd14, 16'd0, 16'd2, 16'd13, 1'b0);
    queue_fields(CP_END, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    // line feed alone and tab alone
    queue_fields(CP_LF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    queue_fields(CP_TAB, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    wait_idle();

    // Fixed settings, extremes among them
    run_phase(16'd100, 16'd12, 16'd6, 16'd4, 300);
    run_phase(16'd0, 16'd0, 16'd0, 16'd0, 150);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 150);
    write_reg(REG_UNUSED, 16'h0123);
    // zero tab stop
    run_phase(16'd200, 16'd20, 16'd8, 16'd0, 200);

    // Random settings
    for (int k = 0; k < 6; k++) begin
      case ($urandom_range(0, 5))
        0:       mlw = 16'd0;
        1:       mlw = 16'hFFFF;
        default: mlw = 16'($urandom_range(16, 600));
      endcase
      lh = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      em = 16'($urandom_range(0, 16));
      tc = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 8));
      run_phase(mlw, lh, em, tc, 180);
    end

    if (mismatches == 0 && area_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
